[hdl/duplicate_request_cache_assert.svh]
// ----------------------------------------------------------------------------
// Duplicate request cache assertion macros
// Shared property wrappers for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_REQUEST_CACHE_ASSERT_SVH
`define DUPLICATE_REQUEST_CACHE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define DRC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("drc assertion failed");

// condition that must never be seen
`define DRC_NEVER(name, cond) \
  `DRC_ASSERT(name, !(cond))

`endif

[hdl/drc_pkg.sv]
// ----------------------------------------------------------------------------
// Duplicate request cache package
// Word types, entry layout, LFSR constants, command and mode codes, states.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int unsigned LFSR_W = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_HANDLE = 1'b1;

  localparam logic MODE_AT_LEAST_ONCE = 1'b0;
  localparam logic MODE_AT_MOST_ONCE  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] request_id;
    logic [31:0] client_addr;
    logic [31:0] response_handle;
  } drc_in_t;

  typedef struct packed {
    logic        found;
    logic        stored;
    logic        evicted;
    logic [3:0]  slot_index;
    logic [31:0] result_handle;
  } drc_out_t;

  typedef struct packed {
    logic [31:0] request;
    logic [31:0] client;
    logic [31:0] response;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_FREE  = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

[hdl/drc_victim.sv]
// ----------------------------------------------------------------------------
// Victim slot generator
// Steps the LFSR once per start, then reduces it modulo ENTRIES by reciprocal
// multiplication: the quotient is registered first, then the remainder.
// ----------------------------------------------------------------------------
module drc_victim import drc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       done_o,
  output logic [$clog2(ENTRIES)-1:0] victim_o
);

  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned SHIFT   = LFSR_W + IDX_W;
  localparam int unsigned RECIP_W = LFSR_W + 1;
  localparam int unsigned PROD_W  = LFSR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
  localparam logic [LFSR_W-1:0] DIVISOR = LFSR_W'(ENTRIES);

  logic [LFSR_W-1:0] lfsr_q, lfsr_nxt;
  logic [PROD_W-1:0] prod;
  logic [LFSR_W-1:0] quo_nxt, quo_q;
  logic [LFSR_W-1:0] back;
  logic [LFSR_W-1:0] rem_q;
  logic              run_q, done_q;

  assign lfsr_nxt = lfsr_next(lfsr_q);
  assign prod     = PROD_W'(lfsr_nxt) * PROD_W'(RECIP);
  assign quo_nxt  = LFSR_W'(prod >> SHIFT);
  assign back     = quo_q * DIVISOR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
      quo_q  <= '0;
      rem_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      lfsr_q <= lfsr_nxt;
      quo_q  <= quo_nxt;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      rem_q  <= lfsr_q - back;
      run_q  <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o   = done_q;
  assign victim_o = rem_q[IDX_W-1:0];

endmodule

[hdl/duplicate_request_cache.sv]
// ----------------------------------------------------------------------------
// Duplicate request cache
// Fully associative request id / client address cache of response handles.
// ----------------------------------------------------------------------------
// One word is processed at a time; in_ready_o is high only while idle, and a
// finished result sits in the output register so the next word can be taken.
// A lookup reads one entry per cycle from the entry memory through one shared
// comparator, up to the first hit or the last entry. A handle word in
// at-least-once mode goes straight to the result register.
// In at-most-once mode the valid bits are walked one per cycle for the lowest
// free slot; with the table full the victim unit adds a reciprocal reduction
// of the LFSR to pick the slot to evict. The next word can be taken in the
// cycle after the result is loaded; the load waits while the receiver still
// holds the previous result. No clearing pass follows reset.
module duplicate_request_cache import drc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  drc_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output drc_out_t out_word_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned SLOT_W = (IDX_W > 4) ? IDX_W : 4;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  state_e             state_q, state_d;
  logic               mode_q;
  logic [ENTRIES-1:0] valid_q;
  drc_in_t            cmd_q, cmd_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   tgt_q, tgt_d;
  logic               evict_q, evict_d;
  drc_out_t           res_q, res_d;
  logic               out_valid_q, out_valid_d;
  drc_out_t           out_q, out_d;

  entry_t             mem [ENTRIES];
  entry_t             rd_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               rd_vld_q;
  logic               mem_we;

  logic               vic_start, vic_done;
  logic [IDX_W-1:0]   vic_slot;
  logic               hit;
  logic [SLOT_W-1:0]  rd_slot, tgt_slot;

  drc_victim #(.ENTRIES(ENTRIES)) u_victim (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (vic_start),
    .done_o   (vic_done),
    .victim_o (vic_slot)
  );

  assign hit = rd_vld_q && valid_q[rd_idx_q] &&
               (rd_q.request == cmd_q.request_id) &&
               (rd_q.client == cmd_q.client_addr);
  assign rd_slot  = SLOT_W'(rd_idx_q);
  assign tgt_slot = SLOT_W'(tgt_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    evict_d     = evict_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    vic_start   = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_word_i;
          cnt_d = '0;
          if (in_word_i.command == CMD_LOOKUP) begin
            state_d = ST_SCAN;
          end else if (mode_q == MODE_AT_MOST_ONCE) begin
            state_d = ST_FREE;
          end else begin
            res_d               = '0;
            res_d.result_handle = in_word_i.response_handle;
            state_d             = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = (cnt_q == LAST) ? cnt_q : cnt_q + IDX_W'(1);
        if (hit) begin
          res_d               = '0;
          res_d.found         = 1'b1;
          res_d.slot_index    = rd_slot[3:0];
          res_d.result_handle = rd_q.response;
          state_d             = ST_DONE;
        end else if (rd_vld_q && (rd_idx_q == LAST)) begin
          res_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_FREE: begin
        if (!valid_q[cnt_q]) begin
          tgt_d   = cnt_q;
          evict_d = 1'b0;
          state_d = ST_WRITE;
        end else if (cnt_q == LAST) begin
          vic_start = 1'b1;
          state_d   = ST_MOD;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_MOD: begin
        if (vic_done) begin
          tgt_d   = vic_slot;
          evict_d = 1'b1;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we              = 1'b1;
        res_d               = '0;
        res_d.stored        = 1'b1;
        res_d.evicted       = evict_q;
        res_d.slot_index    = tgt_slot[3:0];
        res_d.result_handle = cmd_q.response_handle;
        state_d             = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_AT_LEAST_ONCE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        valid_q[tgt_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    tgt_q    <= tgt_d;
    evict_q  <= evict_d;
    res_q    <= res_d;
    out_q    <= out_d;
    rd_idx_q <= cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tgt_q] <= '{request:  cmd_q.request_id,
                      client:   cmd_q.client_addr,
                      response: cmd_q.response_handle};
    end
    rd_q <= mem[cnt_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[hdl/drc_checker.sv]
// ----------------------------------------------------------------------------
// Duplicate request cache checker
// Port-level checks of handshake and result consistency, bound to the top.
// ----------------------------------------------------------------------------
`include "duplicate_request_cache_assert.svh"

module drc_checker import drc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input drc_out_t out_word_o
);

  // result word holds until taken
  `DRC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))

  // one word in flight: busy right after an accept
  `DRC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)

  // a result is either a hit or a store, never both
  `DRC_NEVER(a_hit_xor_store, out_valid_o && out_word_o.found && out_word_o.stored)

  // eviction only on a store
  `DRC_NEVER(a_evict_needs_store, out_valid_o && out_word_o.evicted && !out_word_o.stored)

  // no slot reported without a hit or store
  `DRC_NEVER(a_slot_zero, out_valid_o && !out_word_o.found && !out_word_o.stored &&
                          (out_word_o.slot_index != 4'd0))

endmodule

bind duplicate_request_cache drc_checker u_drc_checker (.*);
